@@ design/bcat_pkg.sv @@
// shared types and operation codes for the byte cell accumulator with top-k selection
// no dependencies; imported by bcat_engine and byte_cell_accumulator_top_k
package bcat_pkg;

    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_READ   = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_MINMAX = 3'd3;
    localparam logic [2:0] FUNC_TOPK   = 3'd4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] cell_index;
        logic [7:0]  add_value;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_value;
        logic        overflow;
        logic [7:0]  min_value;
        logic [11:0] min_index;
        logic [7:0]  max_value;
        logic [11:0] max_index;
        logic [3:0]  rank;
        logic [11:0] top_index;
        logic [7:0]  top_value;
        logic        found;
        logic        last;
    } t_res;

endpackage

@@ design/bcat_engine.sv @@
// cell table memory with a sequencer and one shared add/compare datapath
// covers add, read, clear sweep, min/max scan and top-k selection passes; uses bcat_pkg
module bcat_engine
    import bcat_pkg::*;
#(
    parameter int CELLS     = 4096,
    parameter int TOP_COUNT = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ready
);

    localparam int IW = $clog2(CELLS);
    localparam int CW = IW + 1;
    localparam int RW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_ACC      = 6'b000100,
        S_SCAN     = 6'b001000,
        S_PASS_END = 6'b010000,
        S_RESP     = 6'b100000
    } t_state;

    logic [7:0] mem [CELLS];

    t_state          r_state, n_state;
    t_state          r_resume, n_resume;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_rd_vld, n_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    logic [7:0]      r_rd_data;
    logic [2:0]      r_func, n_func;
    logic [IW-1:0]   r_addr, n_addr;
    logic [7:0]      r_val, n_val;
    t_res            r_res, n_res;
    logic [7:0]      r_mn, n_mn, r_mx, n_mx;
    logic [IW-1:0]   r_mni, n_mni, r_mxi, n_mxi;
    logic [7:0]      r_best_v, n_best_v;
    logic [IW-1:0]   r_best_i, n_best_i;
    logic            r_seen, n_seen, r_more, n_more;
    logic [7:0]      r_prev_v, n_prev_v;
    logic [IW-1:0]   r_prev_i, n_prev_i;
    logic            r_have_prev, n_have_prev;
    logic [RW-1:0]   r_rank, n_rank;

    logic [IW-1:0]   rd_addr, wr_addr;
    logic [7:0]      wr_data;
    logic            mem_we;
    logic            in_range;
    logic [8:0]      sum;
    logic [7:0]      sat;
    logic            cand;
    logic            last_entry;

    assign in_range = (32'(i_req.cell_index) < 32'(CELLS));
    assign sum = {1'b0, r_rd_data} + {1'b0, r_val};
    assign sat = sum[8] ? 8'hFF : sum[7:0];
    // candidate for this pass: ranked after the previous entry and nonzero
    assign cand = (!r_have_prev || (r_rd_data < r_prev_v)
                   || ((r_rd_data == r_prev_v) && (r_rd_idx > r_prev_i)))
                  && (r_rd_data != 8'd0);
    assign last_entry = !r_more || (r_rank == RW'(TOP_COUNT - 1));

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_resume    = r_resume;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_func      = r_func;
        n_addr      = r_addr;
        n_val       = r_val;
        n_res       = r_res;
        n_mn        = r_mn;
        n_mni       = r_mni;
        n_mx        = r_mx;
        n_mxi       = r_mxi;
        n_best_v    = r_best_v;
        n_best_i    = r_best_i;
        n_seen      = r_seen;
        n_more      = r_more;
        n_prev_v    = r_prev_v;
        n_prev_i    = r_prev_i;
        n_have_prev = r_have_prev;
        n_rank      = r_rank;
        rd_addr     = IW'(i_req.cell_index);
        mem_we      = 1'b0;
        wr_addr     = r_addr;
        wr_data     = 8'd0;
        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_cnt[IW-1:0];
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt[IW-1:0] == IW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func      = i_req.func;
                    n_addr      = IW'(i_req.cell_index);
                    n_val       = i_req.add_value;
                    n_res       = '0;
                    n_res.last  = 1'b1;
                    n_resume    = S_IDLE;
                    n_cnt       = '0;
                    n_seen      = 1'b0;
                    n_more      = 1'b0;
                    n_have_prev = 1'b0;
                    n_rank      = '0;
                    case (i_req.func)
                        FUNC_ADD, FUNC_READ: begin
                            n_state = in_range ? S_ACC : S_RESP;
                        end
                        FUNC_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        FUNC_MINMAX, FUNC_TOPK: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACC: begin
                if (r_func == FUNC_ADD) begin
                    mem_we           = 1'b1;
                    wr_data          = sat;
                    n_res.read_value = sat;
                    n_res.overflow   = sum[8];
                end else begin
                    n_res.read_value = r_rd_data;
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                rd_addr = r_cnt[IW-1:0];
                if (r_cnt < CW'(CELLS)) begin
                    n_rd_vld = 1'b1;
                    n_cnt    = r_cnt + CW'(1);
                end
                if (r_rd_vld) begin
                    if (r_func == FUNC_MINMAX) begin
                        if (r_rd_idx == '0) begin
                            n_mn  = r_rd_data;
                            n_mni = r_rd_idx;
                            n_mx  = r_rd_data;
                            n_mxi = r_rd_idx;
                        end else begin
                            if (r_rd_data < r_mn) begin
                                n_mn  = r_rd_data;
                                n_mni = r_rd_idx;
                            end
                            if (r_rd_data >= r_mx) begin
                                n_mx  = r_rd_data;
                                n_mxi = r_rd_idx;
                            end
                        end
                    end else if (cand) begin
                        n_seen = 1'b1;
                        if (r_seen) begin
                            n_more = 1'b1;
                        end
                        if (!r_seen || (r_rd_data > r_best_v)) begin
                            n_best_v = r_rd_data;
                            n_best_i = r_rd_idx;
                        end
                    end
                    if (r_rd_idx == IW'(CELLS - 1)) begin
                        n_state = S_PASS_END;
                    end
                end
            end
            S_PASS_END: begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_resume   = S_IDLE;
                n_state    = S_RESP;
                if (r_func == FUNC_MINMAX) begin
                    n_res.min_value = r_mn;
                    n_res.min_index = 12'(r_mni);
                    n_res.max_value = r_mx;
                    n_res.max_index = 12'(r_mxi);
                end else if (r_seen) begin
                    n_res.rank      = 4'(r_rank);
                    n_res.top_index = 12'(r_best_i);
                    n_res.top_value = r_best_v;
                    n_res.found     = 1'b1;
                    n_res.last      = last_entry;
                    if (!last_entry) begin
                        n_resume    = S_SCAN;
                        n_prev_v    = r_best_v;
                        n_prev_i    = r_best_i;
                        n_have_prev = 1'b1;
                        n_rank      = r_rank + RW'(1);
                        n_cnt       = '0;
                        n_seen      = 1'b0;
                        n_more      = 1'b0;
                    end
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = r_resume;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resume    <= n_resume;
        r_func      <= n_func;
        r_addr      <= n_addr;
        r_val       <= n_val;
        r_res       <= n_res;
        r_mn        <= n_mn;
        r_mni       <= n_mni;
        r_mx        <= n_mx;
        r_mxi       <= n_mxi;
        r_best_v    <= n_best_v;
        r_best_i    <= n_best_i;
        r_seen      <= n_seen;
        r_more      <= n_more;
        r_prev_v    <= n_prev_v;
        r_prev_i    <= n_prev_i;
        r_have_prev <= n_have_prev;
        r_rank      <= n_rank;
    end

`ifndef NO_ASSERTIONS
    a_ready_xor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_res_valid))
        else $error("request ready while a result is pending");

    a_read_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == S_SCAN))
        else $error("scan data valid outside a scan");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.found) |-> (o_res.top_value != 8'd0))
        else $error("top-k entry with zero value");

    a_not_last_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> (r_resume == S_SCAN && o_res.found))
        else $error("non-final result outside a top-k run");
`endif

endmodule

@@ design/byte_cell_accumulator_top_k.sv @@
// top level: stream ports, request unpacking and output register over bcat_engine
// add/read: read, then write back on add; a new request is taken once the result leaves the engine
// min/max: one scan pass over all cells; top-k: one scan pass per reported entry, up to TOP_COUNT entries
// clear: a write sweep over all cells, no result; all scan passes run over the single read port of the cell memory
// reset: synchronous active low; afterwards a clearing pass over all cells holds s_axis_tready low
// uses bcat_pkg and bcat_engine
module byte_cell_accumulator_top_k
    import bcat_pkg::*;
#(
    parameter int CELLS     = 4096,
    parameter int TOP_COUNT = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cell_index, add_value, zero pad
    input  logic [2:0]             s_axis_tuser,   // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_value, overflow, min_value, min_index, max_value, max_index, rank,
    // top_index, top_value, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]             m_axis_tuser,   // found
    output logic                   m_axis_tlast
);

    t_req req;
    t_res eng_res;
    logic eng_res_valid;
    logic eng_res_ready;
    logic r_m_valid;
    t_res r_m_res;

    assign req.func       = s_axis_tuser;
    assign req.cell_index = s_axis_tdata[11:0];
    assign req.add_value  = s_axis_tdata[19:12];

    bcat_engine #(
        .CELLS     (CELLS),
        .TOP_COUNT (TOP_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (s_axis_tready),
        .o_res_valid (eng_res_valid),
        .o_res       (eng_res),
        .i_res_ready (eng_res_ready)
    );

    assign eng_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (eng_res_ready) begin
            r_m_valid <= eng_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_ready && eng_res_valid) begin
            r_m_res <= eng_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_res.top_value, r_m_res.top_index, r_m_res.rank,
                            r_m_res.max_index, r_m_res.max_value, r_m_res.min_index,
                            r_m_res.min_value, r_m_res.overflow, r_m_res.read_value};
    assign m_axis_tuser  = r_m_res.found;
    assign m_axis_tlast  = r_m_res.last;

endmodule

@@ bench/byte_cell_accumulator_top_k_check.sv @@
// stream monitor and result checker for byte_cell_accumulator_top_k
// keeps its own copy of the cell table, predicts every result and compares it in order
// depends on bcat_pkg for the operation codes, stream widths and the result layout
module byte_cell_accumulator_top_k_check
    import bcat_pkg::*;
#(
    parameter int CELLS     = 4096,
    parameter int TOP_COUNT = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [IN_TDATA_W-1:0]  i_req_data,   // cell_index, add_value, zero pad
    input  logic [2:0]             i_req_func,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [OUT_TDATA_W-1:0] i_res_data,
    input  logic [0:0]             i_res_found,
    input  logic                   i_res_last,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] cell_mirror [CELLS];
    t_res       awaited_res [$];
    int         fail_total = 0;
    int         res_seen = 0;

    function automatic string res_text(t_res r);
        return $sformatf({"rd=%0d ovf=%0d min=%0d@%0d max=%0d@%0d rank=%0d top=%0d@%0d",
                          " found=%0d last=%0d"},
                         r.read_value, r.overflow, r.min_value, r.min_index, r.max_value,
                         r.max_index, r.rank, r.top_value, r.top_index, r.found, r.last);
    endfunction

    always @(posedge i_clk) begin : track
        t_res        got;
        t_res        want;
        logic [11:0] idx;
        logic [7:0]  amount;
        int          sum;
        int          v;
        int          best_v;
        int          best_i;
        int          prev_v;
        int          prev_i;
        int          lo_v;
        int          lo_i;
        int          hi_v;
        int          hi_i;
        int          n;
        bit          any;
        bit          bad;
        if (!i_rst_n) begin
            foreach (cell_mirror[i]) cell_mirror[i] = 8'd0;
            awaited_res.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.read_value = i_res_data[7:0];
                got.overflow   = i_res_data[8];
                got.min_value  = i_res_data[16:9];
                got.min_index  = i_res_data[28:17];
                got.max_value  = i_res_data[36:29];
                got.max_index  = i_res_data[48:37];
                got.rank       = i_res_data[52:49];
                got.top_index  = i_res_data[64:53];
                got.top_value  = i_res_data[72:65];
                got.found      = i_res_found[0];
                got.last       = i_res_last;
                if (awaited_res.size() == 0) begin
                    if (fail_total < 10)
                        $display("[%0t] unexpected result %0d: %s", $realtime, res_seen,
                                 res_text(got));
                    fail_total++;
                end else begin
                    want = awaited_res.pop_front();
                    bad = (got.read_value !== want.read_value) ||
                          (got.overflow   !== want.overflow)   ||
                          (got.min_value  !== want.min_value)  ||
                          (got.min_index  !== want.min_index)  ||
                          (got.max_value  !== want.max_value)  ||
                          (got.max_index  !== want.max_index)  ||
                          (got.rank       !== want.rank)       ||
                          (got.top_index  !== want.top_index)  ||
                          (got.top_value  !== want.top_value)  ||
                          (got.found      !== want.found)      ||
                          (got.last       !== want.last);
                    if (bad) begin
                        if (fail_total < 10) begin
                            $display("[%0t] result %0d mismatch", $realtime, res_seen);
                            $display("    expected %s", res_text(want));
                            $display("    actual   %s", res_text(got));
                        end
                        fail_total++;
                    end
                end
                res_seen++;
            end

            if (i_req_valid && i_req_ready) begin
                idx    = i_req_data[11:0];
                amount = i_req_data[19:12];
                case (i_req_func)
                    FUNC_ADD: begin
                        want = '0;
                        if (int'(idx) < CELLS) begin
                            sum = int'(cell_mirror[idx]) + int'(amount);
                            if (sum > 255) begin
                                sum = 255;
                                want.overflow = 1'b1;
                            end
                            cell_mirror[idx] = sum[7:0];
                            want.read_value  = sum[7:0];
                        end
                        want.last = 1'b1;
                        awaited_res.push_back(want);
                    end
                    FUNC_READ: begin
                        want = '0;
                        if (int'(idx) < CELLS) want.read_value = cell_mirror[idx];
                        want.last = 1'b1;
                        awaited_res.push_back(want);
                    end
                    FUNC_CLEAR: begin
                        foreach (cell_mirror[i]) cell_mirror[i] = 8'd0;
                    end
                    FUNC_MINMAX: begin
                        lo_v = int'(cell_mirror[0]);
                        lo_i = 0;
                        hi_v = int'(cell_mirror[0]);
                        hi_i = 0;
                        for (int i = 1; i < CELLS; i++) begin
                            v = int'(cell_mirror[i]);
                            if (v < lo_v) begin
                                lo_v = v;
                                lo_i = i;
                            end
                            if (v >= hi_v) begin
                                hi_v = v;
                                hi_i = i;
                            end
                        end
                        want = '0;
                        want.min_value = lo_v[7:0];
                        want.min_index = lo_i[11:0];
                        want.max_value = hi_v[7:0];
                        want.max_index = hi_i[11:0];
                        want.last      = 1'b1;
                        awaited_res.push_back(want);
                    end
                    FUNC_TOPK: begin
                        n      = 0;
                        prev_v = 256;
                        prev_i = 0;
                        for (int r = 0; r < TOP_COUNT; r++) begin
                            any    = 1'b0;
                            best_v = 0;
                            best_i = 0;
                            for (int i = 0; i < CELLS; i++) begin
                                v = int'(cell_mirror[i]);
                                if ((n == 0 || v < prev_v || (v == prev_v && i > prev_i)) &&
                                    (!any || v > best_v)) begin
                                    best_v = v;
                                    best_i = i;
                                    any    = 1'b1;
                                end
                            end
                            if (!any || best_v == 0) break;
                            want = '0;
                            want.rank      = r[3:0];
                            want.top_index = best_i[11:0];
                            want.top_value = best_v[7:0];
                            want.found     = 1'b1;
                            awaited_res.push_back(want);
                            n++;
                            prev_v = best_v;
                            prev_i = best_i;
                        end
                        if (n == 0) begin
                            want = '0;
                            want.last = 1'b1;
                        end else begin
                            want = awaited_res.pop_back();
                            want.last = 1'b1;
                        end
                        awaited_res.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= awaited_res.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ bench/byte_cell_accumulator_top_k_tb.sv @@
// top of the bench for byte_cell_accumulator_top_k: clock, reset, requests and verdict
// drives directed then random requests with random gaps and two long result hold-offs
// depends on bcat_pkg, the block and byte_cell_accumulator_top_k_check
module byte_cell_accumulator_top_k_tb;
    import bcat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CELLS        = 4096;
    localparam int          TOP_COUNT    = 10;
    localparam int          RANDOM_REQS  = 460;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          DRAIN_CYCLES = 5000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          HOT_CELLS    = 24;
    localparam logic [2:0]  FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  FUNC_SPARE_LAST  = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data = '0;
    logic [2:0]             req_func = FUNC_ADD;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;
    logic [0:0]             res_found;
    logic                   res_last;
    int                     fail_count;
    int                     pending;
    bit                     req_calm = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    byte_cell_accumulator_top_k #(
        .CELLS     (CELLS),
        .TOP_COUNT (TOP_COUNT)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (req_ready),
        .s_axis_tdata  (req_data),
        .s_axis_tuser  (req_func),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data),
        .m_axis_tuser  (res_found),
        .m_axis_tlast  (res_last)
    );

    byte_cell_accumulator_top_k_check #(
        .CELLS     (CELLS),
        .TOP_COUNT (TOP_COUNT)
    ) check_u (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_req_func   (req_func),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_res_found  (res_found),
        .i_res_last   (res_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_req(input logic [2:0] func, input logic [11:0] idx,
                            input logic [7:0] val);
        int gap;
        if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
        gap = req_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= func;
        req_data  <= {4'b0000, val, idx};
        do @(posedge clk); while (!req_ready);
    endtask

    // result side: random gaps, calm stretches and two long hold-offs
    initial begin : res_side
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 9);
            if (taken == 60 || taken == 250) gap = HOLD_CYCLES;
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready)) idle = 0;
            else idle++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stim
        int          hot_cells [HOT_CELLS];
        int          counted;
        int          pick;
        logic [2:0]  func;
        logic [11:0] idx;
        logic [7:0]  val;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        hot_cells[0] = 0;
        hot_cells[1] = CELLS - 1;
        for (int i = 2; i < HOT_CELLS; i++) hot_cells[i] = $urandom_range(0, CELLS - 1);

        // directed: empty table, extremes, saturation, ties, spare codes, clear
        send_req(FUNC_TOPK, 12'h000, 8'h00);
        send_req(FUNC_MINMAX, 12'h000, 8'h00);
        send_req(FUNC_READ, 12'h000, 8'h00);
        send_req(FUNC_READ, 12'hFFF, 8'h00);
        send_req(FUNC_ADD, 12'h000, 8'hFF);
        send_req(FUNC_ADD, 12'h000, 8'h01);
        send_req(FUNC_ADD, 12'hFFF, 8'h00);
        send_req(FUNC_ADD, 12'hFFF, 8'd200);
        send_req(FUNC_ADD, 12'hFFF, 8'd55);
        send_req(FUNC_ADD, 12'd7, 8'd200);
        send_req(FUNC_ADD, 12'd100, 8'd200);
        send_req(FUNC_ADD, 12'd5, 8'd1);
        send_req(FUNC_ADD, 12'hAAA, 8'h55);
        send_req(FUNC_ADD, 12'h555, 8'hAA);
        send_req(FUNC_READ, 12'h000, 8'h00);
        send_req(FUNC_MINMAX, 12'h000, 8'h00);
        send_req(FUNC_TOPK, 12'h000, 8'h00);
        for (logic [3:0] f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            send_req(f[2:0], 12'h5A5, 8'hA5);
        send_req(FUNC_CLEAR, 12'h000, 8'h00);
        send_req(FUNC_MINMAX, 12'h000, 8'h00);
        send_req(FUNC_READ, 12'h555, 8'h00);

        // random: mostly adds on a hot set so saturation and ties build up
        counted = 0;
        while (counted < RANDOM_REQS) begin
            pick = $urandom_range(0, 999);
            idx  = ($urandom_range(0, 3) != 0)
                   ? 12'(hot_cells[$urandom_range(0, HOT_CELLS - 1)])
                   : 12'($urandom_range(0, CELLS - 1));
            val  = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                        : 8'($urandom_range(0, 255));
            if (pick < 20)       func = FUNC_TOPK;
            else if (pick < 50)  func = FUNC_MINMAX;
            else if (pick < 70)  func = FUNC_CLEAR;
            else if (pick < 320) func = FUNC_READ;
            else if (pick < 970) func = FUNC_ADD;
            else                 func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
            send_req(func, idx, val);
            if (func <= FUNC_TOPK) counted++;
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
